### src/hsge_pkg.sv
`timescale 1ns / 1ps

package hsge_pkg;

    localparam int LEGS         = 6;
    localparam int OFFSET_WIDTH = 16;
    localparam int LEG_W        = 3;
    localparam int LIFT_W       = 14;
    localparam int STEP_W       = 5;
    localparam int HOLD_W       = 8;
    localparam int PERIOD_W     = 16;
    localparam int SPEED_W      = 16;
    localparam int FOOT_W       = 16;
    localparam int GAIT_W       = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int AXES         = 3;
    localparam int AXIS_W       = 2;
    localparam int PROD_W       = SPEED_W + PERIOD_W + 1;
    localparam int DELTA_W      = PROD_W - 16;
    localparam int PUSH_W       = PROD_W + 5;
    localparam int SAT_IN_W     = 40;

    localparam logic signed [SPEED_W-1:0] MOVE_LIN = 16'sd163;
    localparam logic signed [SPEED_W-1:0] MOVE_ROT = 16'sd204;
    localparam logic signed [FOOT_W-1:0]  HOME_Z   = -16'sd3277;

    localparam logic [GAIT_W-1:0] GAIT_RIPPLE = 2'd0;
    localparam logic [GAIT_W-1:0] GAIT_AMBLE  = 2'd1;
    localparam logic [GAIT_W-1:0] GAIT_TRIPOD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GAIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd3;

    localparam logic [LIFT_W-1:0]   LIFT_RESET   = 14'd1966;
    localparam logic [HOLD_W-1:0]   HOLD_RESET   = 8'd1;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd6423;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_READ,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic signed [OFFSET_WIDTH-1:0] x;
        logic signed [OFFSET_WIDTH-1:0] y;
        logic        [LIFT_W-1:0]       z;
        logic signed [OFFSET_WIDTH-1:0] rot;
    } leg_off_t;

    function automatic logic [STEP_W-1:0] cycle_len(input logic [GAIT_W-1:0] g);
        case (g)
            GAIT_RIPPLE: cycle_len = 5'd24;
            GAIT_AMBLE:  cycle_len = 5'd12;
            default:     cycle_len = 5'd8;
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] phase_of(input logic [GAIT_W-1:0] g,
                                                   input logic [LEG_W-1:0] leg);
        logic [STEP_W-1:0] p;
        p = '0;
        case (g)
            GAIT_RIPPLE:
            begin
                case (leg)
                    3'd0:    p = 5'd12;
                    3'd1:    p = 5'd0;
                    3'd2:    p = 5'd8;
                    3'd3:    p = 5'd20;
                    3'd4:    p = 5'd4;
                    default: p = 5'd16;
                endcase
            end
            GAIT_AMBLE:
            begin
                case (leg)
                    3'd0:    p = 5'd4;
                    3'd1:    p = 5'd0;
                    3'd2:    p = 5'd8;
                    3'd3:    p = 5'd8;
                    3'd4:    p = 5'd0;
                    default: p = 5'd4;
                endcase
            end
            default:
            begin
                case (leg)
                    3'd0:    p = 5'd4;
                    3'd1:    p = 5'd0;
                    3'd2:    p = 5'd0;
                    3'd3:    p = 5'd4;
                    3'd4:    p = 5'd4;
                    default: p = 5'd0;
                endcase
            end
        endcase
        return p;
    endfunction

    function automatic logic signed [FOOT_W-1:0] home_x(input logic [LEG_W-1:0] leg);
        case (leg)
            3'd0, 3'd1: home_x = 16'sd4915;
            3'd2, 3'd3: home_x = 16'sd0;
            default:    home_x = -16'sd4915;
        endcase
    endfunction

    function automatic logic signed [FOOT_W-1:0] home_y(input logic [LEG_W-1:0] leg);
        case (leg)
            3'd0, 3'd4: home_y = 16'sd6554;
            3'd1, 3'd5: home_y = -16'sd6554;
            3'd2:       home_y = 16'sd7864;
            default:    home_y = -16'sd7864;
        endcase
    endfunction

    function automatic logic signed [OFFSET_WIDTH-1:0] sat_off(
        input logic signed [SAT_IN_W-1:0] v);
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = (SAT_IN_W'(1) <<< (OFFSET_WIDTH - 1)) - SAT_IN_W'(1);
        lo = -hi - SAT_IN_W'(1);
        if (v > hi)
            sat_off = hi[OFFSET_WIDTH-1:0];
        else if (v < lo)
            sat_off = lo[OFFSET_WIDTH-1:0];
        else
            sat_off = v[OFFSET_WIDTH-1:0];
    endfunction

    function automatic logic signed [FOOT_W-1:0] sat_foot(
        input logic signed [SAT_IN_W-1:0] v);
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = (SAT_IN_W'(1) <<< (FOOT_W - 1)) - SAT_IN_W'(1);
        lo = -hi - SAT_IN_W'(1);
        if (v > hi)
            sat_foot = hi[FOOT_W-1:0];
        else if (v < lo)
            sat_foot = lo[FOOT_W-1:0];
        else
            sat_foot = v[FOOT_W-1:0];
    endfunction

    function automatic logic signed [OFFSET_WIDTH-1:0] half_tz(
        input logic signed [OFFSET_WIDTH-1:0] v);
        logic signed [OFFSET_WIDTH:0] t;
        t = (OFFSET_WIDTH + 1)'(v) + $signed({{OFFSET_WIDTH{1'b0}}, v[OFFSET_WIDTH-1]});
        t = t >>> 1;
        return t[OFFSET_WIDTH-1:0];
    endfunction

endpackage

### src/hsge_tick_if.sv
`timescale 1ns / 1ps

interface hsge_tick_if
    import hsge_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] speed_x;
    logic signed [SPEED_W-1:0] speed_y;
    logic signed [SPEED_W-1:0] speed_rot;

    modport source (output valid, output speed_x, output speed_y, output speed_rot,
                    input ready);
    modport sink   (input valid, input speed_x, input speed_y, input speed_rot,
                    output ready);
endinterface

### src/hsge_leg_if.sv
`timescale 1ns / 1ps

interface hsge_leg_if
    import hsge_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic        [LEG_W-1:0]        leg_index;
    logic signed [FOOT_W-1:0]       foot_x;
    logic signed [FOOT_W-1:0]       foot_y;
    logic signed [FOOT_W-1:0]       foot_z;
    logic signed [OFFSET_WIDTH-1:0] offset_x;
    logic signed [OFFSET_WIDTH-1:0] offset_y;
    logic        [LIFT_W-1:0]       offset_z;
    logic signed [OFFSET_WIDTH-1:0] offset_rot;
    logic                           last_leg;

    modport source (output valid, output leg_index, output foot_x, output foot_y,
                    output foot_z, output offset_x, output offset_y, output offset_z,
                    output offset_rot, output last_leg, input ready);
    modport sink   (input valid, input leg_index, input foot_x, input foot_y,
                    input foot_z, input offset_x, input offset_y, input offset_z,
                    input offset_rot, input last_leg, output ready);
endinterface

### src/hexapod_smooth_gait_engine.sv
`timescale 1ns / 1ps

// Hexapod gait engine: each tick beat carries forward, sideways and rotation speeds and
// produces six leg beats, legs 0 to 5, the last flagged by last_leg. A tick is accepted
// in the idle state; the push and swing strides are then formed in the prep state through
// a single shared 17x17 multiplier (one speed axis per cycle), then each leg passes the
// read-modify-write path of the leg offset memory (read, then update and write back).
// A stalled output holds the leg loop in its update cycle. The last leg beat may still
// wait in the output register while the next tick is accepted. Configuration writes must
// only be made while the engine is idle; the engine itself does not enforce this. A gait
// pattern write that changes the pattern restarts the step counter.
module hexapod_smooth_gait_engine
    import hsge_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    hsge_tick_if.sink             tick,
    hsge_leg_if.source            leg
);

    state_t state_reg, state_next;

    logic [GAIT_W-1:0]   gait_reg;
    logic [LIFT_W-1:0]   lift_reg;
    logic [HOLD_W-1:0]   hold_cfg_reg;
    logic [PERIOD_W-1:0] period_reg;

    logic [STEP_W-1:0] step_count_reg;
    logic [HOLD_W-1:0] stopped_reg;
    logic              moving_reg;
    logic              hold_reg;

    logic [AXIS_W-1:0] prep_cnt_reg;
    logic [LEG_W-1:0]  leg_reg;

    logic signed [SPEED_W-1:0]      sx_reg, sy_reg, sr_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [DELTA_W-1:0]      delta_reg [AXES];
    logic signed [OFFSET_WIDTH-1:0] half_reg  [AXES];
    logic signed [OFFSET_WIDTH-1:0] down_reg  [AXES];

    leg_off_t          mem [LEGS];
    logic [LEGS-1:0]   valid_reg;
    leg_off_t          rd_data_reg;
    logic              rd_valid_reg;

    logic                           out_valid_reg;
    logic        [LEG_W-1:0]        out_leg_reg;
    logic signed [FOOT_W-1:0]       foot_x_reg, foot_y_reg, foot_z_reg;
    leg_off_t                       out_off_reg;

    logic tick_ready;
    logic tick_fire;
    logic prep_active;
    logic rd_en;
    logic upd_fire;

    logic [GAIT_W-1:0] g_eff;
    logic [STEP_W-1:0] cyc;
    logic [STEP_W-1:0] st;
    logic [STEP_W-1:0] ph, ph1, ph2, ph3;

    logic signed [SPEED_W-1:0]  mul_speed;
    logic signed [PROD_W-1:0]   mul_out;
    logic signed [PUSH_W-1:0]   push_q;
    logic signed [PUSH_W-1:0]   half_rnd;
    logic signed [PUSH_W-1:0]   down_rnd;
    logic signed [PROD_W-1:0]   delta_rnd;
    logic [AXIS_W-1:0]          derive_idx;

    logic     tick_moving;
    leg_off_t cur;
    leg_off_t upd;
    logic     has_off;

    assign g_eff = (gait_reg == GAIT_RIPPLE || gait_reg == GAIT_AMBLE) ? gait_reg : GAIT_TRIPOD;
    assign cyc   = cycle_len(g_eff);
    assign st    = (step_count_reg >= cyc) ? step_count_reg - cyc : step_count_reg;
    assign ph    = phase_of(g_eff, leg_reg);
    assign ph1   = ph + STEP_W'(1);
    assign ph2   = ph + STEP_W'(2);
    assign ph3   = ph + STEP_W'(3);

    assign tick_fire = tick.valid && tick_ready;
    assign tick.ready = tick_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick.valid)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (prep_cnt_reg == AXIS_W'(AXES))
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!out_valid_reg || leg.ready)
                    state_next = (leg_reg == LEG_W'(LEGS - 1)) ? ST_IDLE : ST_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        tick_ready  = 1'b0;
        prep_active = 1'b0;
        rd_en       = 1'b0;
        upd_fire    = 1'b0;
        case (state_reg)
            ST_IDLE:   tick_ready  = 1'b1;
            ST_PREP:   prep_active = 1'b1;
            ST_READ:   rd_en       = 1'b1;
            ST_UPDATE: upd_fire    = !out_valid_reg || leg.ready;
            default:   tick_ready  = 1'b0;
        endcase
    end

    // stride arithmetic, one axis per cycle
    always_comb
    begin
        case (prep_cnt_reg)
            2'd0:    mul_speed = sx_reg;
            2'd1:    mul_speed = sy_reg;
            default: mul_speed = sr_reg;
        endcase
        mul_out = $signed({mul_speed[SPEED_W-1], mul_speed}) * $signed({1'b0, period_reg});
        case (g_eff)
            GAIT_RIPPLE: push_q = (PUSH_W'(prod_reg) <<< 4) + (PUSH_W'(prod_reg) <<< 2);
            GAIT_AMBLE:  push_q = PUSH_W'(prod_reg) <<< 3;
            default:     push_q = PUSH_W'(prod_reg) <<< 2;
        endcase
        half_rnd   = (push_q + (PUSH_W'(1) <<< 17)) >>> 18;
        down_rnd   = (push_q + (PUSH_W'(1) <<< 16)) >>> 17;
        delta_rnd  = prod_reg + (PROD_W'(1) <<< 15);
        derive_idx = prep_cnt_reg - AXIS_W'(1);
    end

    assign tick_moving = tick.speed_x > MOVE_LIN || tick.speed_x < -MOVE_LIN
                      || tick.speed_y > MOVE_LIN || tick.speed_y < -MOVE_LIN
                      || tick.speed_rot > MOVE_ROT || tick.speed_rot < -MOVE_ROT;

    // leg update
    always_comb
    begin
        cur     = rd_valid_reg ? rd_data_reg : '0;
        upd     = cur;
        has_off = cur.x != '0 || cur.y != '0;
        if (moving_reg)
        begin
            if (st == ph)
            begin
                upd.x   = half_tz(cur.x);
                upd.y   = half_tz(cur.y);
                upd.z   = lift_reg >> 1;
                upd.rot = half_tz(cur.rot);
            end
            else if (st == ph1 && cur.z != '0)
            begin
                upd.x   = '0;
                upd.y   = '0;
                upd.z   = lift_reg;
                upd.rot = '0;
            end
            else if (st == ph2 && cur.z != '0)
            begin
                upd.x   = half_reg[0];
                upd.y   = half_reg[1];
                upd.z   = lift_reg >> 1;
                upd.rot = half_reg[2];
            end
            else if (st == ph3 && cur.z != '0)
            begin
                upd.x   = down_reg[0];
                upd.y   = down_reg[1];
                upd.z   = '0;
                upd.rot = down_reg[2];
            end
            else
            begin
                upd.x   = sat_off(SAT_IN_W'(cur.x) - SAT_IN_W'(delta_reg[0]));
                upd.y   = sat_off(SAT_IN_W'(cur.y) - SAT_IN_W'(delta_reg[1]));
                upd.z   = '0;
                upd.rot = sat_off(SAT_IN_W'(cur.rot) - SAT_IN_W'(delta_reg[2]));
            end
        end
        else if (!hold_reg)
        begin
            if (st == ph && has_off && cur.z == '0)
            begin
                upd.x   = half_tz(cur.x);
                upd.y   = half_tz(cur.y);
                upd.z   = lift_reg >> 1;
                upd.rot = half_tz(cur.rot);
            end
            else if (st == ph1 && has_off && cur.z != '0)
            begin
                upd.x   = '0;
                upd.y   = '0;
                upd.z   = lift_reg;
                upd.rot = '0;
            end
            else
            begin
                upd.z = '0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            gait_reg       <= GAIT_TRIPOD;
            lift_reg       <= LIFT_RESET;
            hold_cfg_reg   <= HOLD_RESET;
            period_reg     <= PERIOD_RESET;
            step_count_reg <= '0;
            stopped_reg    <= '0;
            moving_reg     <= 1'b0;
            hold_reg       <= 1'b0;
            prep_cnt_reg   <= '0;
            leg_reg        <= '0;
            valid_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIT:
                    begin
                        if (cfg_data[GAIT_W-1:0] != gait_reg)
                            step_count_reg <= '0;
                        gait_reg <= cfg_data[GAIT_W-1:0];
                    end
                    REG_LIFT:   lift_reg     <= cfg_data[LIFT_W-1:0];
                    REG_HOLD:   hold_cfg_reg <= cfg_data[HOLD_W-1:0];
                    REG_PERIOD: period_reg   <= cfg_data[PERIOD_W-1:0];
                    default:    period_reg   <= period_reg;
                endcase
            end

            if (tick_fire)
            begin
                moving_reg   <= tick_moving;
                prep_cnt_reg <= '0;
                leg_reg      <= '0;
                if (tick_moving)
                begin
                    stopped_reg <= '0;
                    hold_reg    <= 1'b0;
                end
                else if (stopped_reg < hold_cfg_reg)
                begin
                    stopped_reg <= stopped_reg + HOLD_W'(1);
                    hold_reg    <= 1'b1;
                end
                else
                begin
                    hold_reg <= 1'b0;
                end
            end

            if (prep_active && prep_cnt_reg != AXIS_W'(AXES))
                prep_cnt_reg <= prep_cnt_reg + AXIS_W'(1);

            if (rd_en)
                rd_valid_reg <= valid_reg[leg_reg];

            if (upd_fire)
            begin
                valid_reg[leg_reg] <= 1'b1;
                leg_reg            <= leg_reg + LEG_W'(1);
                if (leg_reg == LEG_W'(LEGS - 1))
                    step_count_reg <= (st == cyc - STEP_W'(1)) ? '0 : st + STEP_W'(1);
            end

            if (upd_fire)
                out_valid_reg <= 1'b1;
            else if (leg.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            sx_reg <= tick.speed_x;
            sy_reg <= tick.speed_y;
            sr_reg <= tick.speed_rot;
        end
        if (prep_active)
        begin
            if (prep_cnt_reg != AXIS_W'(AXES))
                prod_reg <= mul_out;
            if (prep_cnt_reg != '0)
            begin
                delta_reg[derive_idx] <= delta_rnd[PROD_W-1:16];
                half_reg[derive_idx]  <= sat_off(SAT_IN_W'(half_rnd));
                down_reg[derive_idx]  <= sat_off(SAT_IN_W'(down_rnd));
            end
        end
        if (upd_fire)
        begin
            out_leg_reg <= leg_reg;
            out_off_reg <= upd;
            foot_x_reg  <= sat_foot(SAT_IN_W'(home_x(leg_reg)) + SAT_IN_W'(upd.x));
            foot_y_reg  <= sat_foot(SAT_IN_W'(home_y(leg_reg)) + SAT_IN_W'(upd.y));
            foot_z_reg  <= sat_foot(SAT_IN_W'(HOME_Z) + $signed(SAT_IN_W'(upd.z)));
        end
    end

    // leg offset memory
    always_ff @(posedge clk)
    begin
        if (upd_fire)
            mem[leg_reg] <= upd;
        if (rd_en)
            rd_data_reg <= mem[leg_reg];
    end

    assign leg.valid      = out_valid_reg;
    assign leg.leg_index  = out_leg_reg;
    assign leg.foot_x     = foot_x_reg;
    assign leg.foot_y     = foot_y_reg;
    assign leg.foot_z     = foot_z_reg;
    assign leg.offset_x   = out_off_reg.x;
    assign leg.offset_y   = out_off_reg.y;
    assign leg.offset_z   = out_off_reg.z;
    assign leg.offset_rot = out_off_reg.rot;
    assign leg.last_leg   = (out_leg_reg == LEG_W'(LEGS - 1));

endmodule
